// ===== rtl/dense_layer_mac_core_macros.svh =====
// ----------------------------------------------------------------------------
// dense_layer_mac_core assertion macros
// Concurrent assertion helpers, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DENSE_LAYER_MAC_CORE_MACROS_SVH
`define DENSE_LAYER_MAC_CORE_MACROS_SVH

`ifndef SYNTHESIS
// condition holds at every edge out of reset
`define DLM_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("dense layer mac: invariant violated");
// consequent holds in the cycle after antecedent
`define DLM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dense layer mac: sequence violated");
`else
`define DLM_ASSERT(lbl, cond)
`define DLM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/dlm_pkg.sv =====
// ----------------------------------------------------------------------------
// dlm_pkg
// Shared constants, codes and types of the dense layer multiply-accumulate core.
// ----------------------------------------------------------------------------
package dlm_pkg;

  // sizing
  localparam int MAX_INPUTS  = 64;
  localparam int MAX_NEURONS = 64;
  localparam int ADDR_W      = $clog2(MAX_INPUTS);
  localparam int COL_W       = $clog2(MAX_INPUTS + 1);
  localparam int ROW_W       = $clog2(MAX_NEURONS + 1);

  // field widths
  localparam int DATA_W    = 16;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = 40;
  localparam int FRAC_BITS = 12;
  localparam int SHIFT_W   = ACC_W - FRAC_BITS;
  localparam int CFG_W     = 7;
  localparam int SLOT_W    = 6;
  localparam int NEURON_W  = 6;
  localparam int CFG_IDX_W = 1;

  // saturation bounds
  localparam logic signed [DATA_W-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 16'sh8000;

  // register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_INPUTS  = 1'b0;
  localparam cfg_idx_t REG_NEURONS = 1'b1;

  // reset values of the count registers
  localparam logic [CFG_W-1:0] INPUTS_RST  = 7'd32;
  localparam logic [CFG_W-1:0] NEURONS_RST = 7'd64;

  // input word opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_WEIGHT = 1'b1;

  // control travelling with a weight word
  typedef struct packed {
    logic                first;
    logic                done;
    logic                last;
    logic [NEURON_W-1:0] neuron;
  } item_ctl_t;

  // zero acts as one, above the maximum acts as the maximum
  function automatic int clamp_count(input logic [CFG_W-1:0] v, input int maxv);
    int r;
    r = int'(v);
    if (r == 0) begin
      r = 1;
    end else if (r > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

// ===== rtl/dlm_ram.sv =====
// ----------------------------------------------------------------------------
// dlm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dlm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/dlm_seq.sv =====
// ----------------------------------------------------------------------------
// dlm_seq
// Input side: count registers, column and row counters, store access and the
// first pipeline register for weight words.
// ----------------------------------------------------------------------------
`include "dense_layer_mac_core_macros.svh"

module dlm_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  dlm_pkg::cfg_idx_t              cfg_index,
  input  logic [dlm_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_op,
  input  logic [dlm_pkg::SLOT_W-1:0]     in_slot,
  input  logic signed [dlm_pkg::DATA_W-1:0] in_value,
  input  logic signed [dlm_pkg::DATA_W-1:0] in_bias,
  input  logic                           adv,
  output logic                           ram_we,
  output logic [dlm_pkg::ADDR_W-1:0]     ram_waddr,
  output logic [dlm_pkg::DATA_W-1:0]     ram_wdata,
  output logic                           ram_re,
  output logic [dlm_pkg::ADDR_W-1:0]     ram_raddr,
  output logic                           s1_vld,
  output dlm_pkg::item_ctl_t             s1_ctl,
  output logic signed [dlm_pkg::DATA_W-1:0] s1_value,
  output logic signed [dlm_pkg::DATA_W-1:0] s1_bias
);
  import dlm_pkg::*;

  logic [CFG_W-1:0]         inputs_r;
  logic [CFG_W-1:0]         neurons_r;
  logic [COL_W-1:0]         column_r;
  logic [COL_W-1:0]         column_nxt;
  logic [ROW_W-1:0]         row_r;
  logic [ROW_W-1:0]         row_nxt;
  logic [COL_W-1:0]         n_in;
  logic [ROW_W-1:0]         n_neu;
  logic [COL_W-1:0]         col_inc;
  logic [ROW_W-1:0]         row_inc;
  logic                     accept;
  logic                     wt_acc;
  logic                     row_done;
  logic                     layer_last;
  logic                     s1_vld_r;
  item_ctl_t                s1_ctl_r;
  logic signed [DATA_W-1:0] s1_value_r;
  logic signed [DATA_W-1:0] s1_bias_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inputs_r  <= INPUTS_RST;
      neurons_r <= NEURONS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INPUTS:  inputs_r  <= cfg_wdata;
        REG_NEURONS: neurons_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // counts in force
  assign n_in  = COL_W'(clamp_count(inputs_r, MAX_INPUTS));
  assign n_neu = ROW_W'(clamp_count(neurons_r, MAX_NEURONS));

  // handshake
  assign accept = in_valid && adv;
  assign wt_acc = accept && (in_op == OP_WEIGHT);

  // column and row stepping
  assign col_inc    = column_r + COL_W'(1);
  assign row_inc    = row_r + ROW_W'(1);
  assign row_done   = (col_inc >= n_in);
  assign layer_last = (row_inc >= n_neu);
  assign column_nxt = row_done ? '0 : col_inc;
  assign row_nxt    = !row_done ? row_r : (layer_last ? '0 : row_inc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      row_r    <= '0;
    end else if (wt_acc) begin
      column_r <= column_nxt;
      row_r    <= row_nxt;
    end
  end

  // activation store access
  assign ram_we    = accept && (in_op == OP_LOAD) && (int'(in_slot) < MAX_INPUTS);
  assign ram_waddr = ADDR_W'(in_slot);
  assign ram_wdata = in_value;
  assign ram_re    = wt_acc;
  assign ram_raddr = column_r[ADDR_W-1:0];

  // first stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= wt_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (wt_acc) begin
      s1_ctl_r.first  <= (column_r == '0);
      s1_ctl_r.done   <= row_done;
      s1_ctl_r.last   <= layer_last;
      s1_ctl_r.neuron <= row_r[NEURON_W-1:0];
      s1_value_r      <= in_value;
      s1_bias_r       <= in_bias;
    end
  end

  assign s1_vld   = s1_vld_r;
  assign s1_ctl   = s1_ctl_r;
  assign s1_value = s1_value_r;
  assign s1_bias  = s1_bias_r;

  // counters stay inside the store and the layer
  `DLM_ASSERT(a_column_range, column_r < COL_W'(MAX_INPUTS))
  `DLM_ASSERT(a_row_range, row_r < ROW_W'(MAX_NEURONS))

endmodule

// ===== rtl/dlm_mac.sv =====
// ----------------------------------------------------------------------------
// dlm_mac
// Multiply-accumulate on the 40-bit accumulator, then shift, saturate and
// hold the result word in the output register.
// ----------------------------------------------------------------------------
`include "dense_layer_mac_core_macros.svh"

module dlm_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              s1_vld,
  input  dlm_pkg::item_ctl_t                s1_ctl,
  input  logic signed [dlm_pkg::DATA_W-1:0] s1_value,
  input  logic signed [dlm_pkg::DATA_W-1:0] s1_bias,
  input  logic signed [dlm_pkg::DATA_W-1:0] act_rd,
  input  logic                              out_stall,
  output logic                              adv,
  output logic                              out_valid,
  output logic [dlm_pkg::NEURON_W-1:0]      out_neuron,
  output logic signed [dlm_pkg::DATA_W-1:0] out_activation,
  output logic                              out_clipped,
  output logic                              out_final_res
);
  import dlm_pkg::*;

  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   base;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic                      s2_vld_r;
  logic                      s2_last_r;
  logic [NEURON_W-1:0]       s2_neuron_r;
  logic signed [SHIFT_W-1:0] shifted;
  logic signed [DATA_W-1:0]  sat_val;
  logic                      sat_clip;
  logic                      out_vld_r;
  logic [NEURON_W-1:0]       out_neuron_r;
  logic signed [DATA_W-1:0]  out_act_r;
  logic                      out_clip_r;
  logic                      out_last_r;
  logic                      at_rail;

  // the whole pipe moves when the output register is free
  assign adv = !out_vld_r || !out_stall;

  // multiply-accumulate, bias seeds the first column
  assign prod    = act_rd * s1_value;
  assign base    = s1_ctl.first ? ACC_W'(s1_bias) : acc_r;
  assign acc_nxt = base + ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (adv && s1_vld) begin
      acc_r <= acc_nxt;
    end
  end

  // row-complete marker alongside the accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld && s1_ctl.done;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_vld) begin
      s2_last_r   <= s1_ctl.last;
      s2_neuron_r <= s1_ctl.neuron;
    end
  end

  // arithmetic shift and saturation to int16
  assign shifted = $signed(acc_r[ACC_W-1:FRAC_BITS]);

  always_comb begin
    sat_clip = 1'b1;
    if (shifted > SHIFT_W'(SAT_MAX)) begin
      sat_val = SAT_MAX;
    end else if (shifted < SHIFT_W'(SAT_MIN)) begin
      sat_val = SAT_MIN;
    end else begin
      sat_val  = shifted[DATA_W-1:0];
      sat_clip = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_vld_r) begin
      out_neuron_r <= s2_neuron_r;
      out_act_r    <= sat_val;
      out_clip_r   <= sat_clip;
      out_last_r   <= s2_last_r;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_neuron     = out_neuron_r;
  assign out_activation = out_act_r;
  assign out_clipped    = out_clip_r;
  assign out_final_res  = out_last_r;

  // held value sits on one of the int16 rails
  assign at_rail = (out_act_r == SAT_MAX) || (out_act_r == SAT_MIN);

  // a finished row always lands in the output register
  `DLM_ASSERT_NEXT(a_row_to_out, s2_vld_r && adv, out_vld_r)
  // a clipped word carries a rail value
  `DLM_ASSERT(a_clip_rail, !(out_vld_r && out_clip_r) || at_rail)

endmodule

// ===== rtl/dense_layer_mac_core.sv =====
// ----------------------------------------------------------------------------
// dense_layer_mac_core
// Streaming int16 fully connected layer with a 40-bit accumulator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): a load word (in_op = 0) writes
//   in_value into activation slot in_slot; a weight word (in_op = 1) carries
//   the next weight in row-major order, and in_bias is taken on the first
//   weight of each row. Load words give no result.
//   Output channel (out_valid / out_stall): one word per finished row with
//   neuron index, shifted and saturated sum, clip flag and last-neuron flag.
//   Config port: cfg_we with cfg_index 0 sets inputs per row, 1 sets neurons.
//   Throughput: one word per cycle, loads and weights alike, while in_stall is low.
//   Result path: after the last weight of a row is accepted, the store read and
//   first stage register take it on the accepting edge, then it is accumulated,
//   then shifted and saturated into the output register.
//   Stall: while out_stall holds a waiting result, the whole pipe freezes
//   and in_stall is raised; with the output free, in_stall stays low.
//   Reset (synchronous, rst_n low): counters and accumulator clear, counts go
//   to 32 inputs and 64 neurons; the activation store is not cleared.
// ----------------------------------------------------------------------------
module dense_layer_mac_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  dlm_pkg::cfg_idx_t                 cfg_index,
  input  logic [dlm_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_op,
  input  logic [dlm_pkg::SLOT_W-1:0]        in_slot,
  input  logic signed [dlm_pkg::DATA_W-1:0] in_value,
  input  logic signed [dlm_pkg::DATA_W-1:0] in_bias,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dlm_pkg::NEURON_W-1:0]      out_neuron,
  output logic signed [dlm_pkg::DATA_W-1:0] out_activation,
  output logic                              out_clipped,
  output logic                              out_final_res
);
  import dlm_pkg::*;

  logic                     adv;
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic                     ram_re;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;
  logic                     s1_vld;
  item_ctl_t                s1_ctl;
  logic signed [DATA_W-1:0] s1_value;
  logic signed [DATA_W-1:0] s1_bias;

  assign in_stall = !adv;

  // counters and first stage
  dlm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_slot   (in_slot),
    .in_value  (in_value),
    .in_bias   (in_bias),
    .adv       (adv),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .s1_vld    (s1_vld),
    .s1_ctl    (s1_ctl),
    .s1_value  (s1_value),
    .s1_bias   (s1_bias)
  );

  // activation store
  dlm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_INPUTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // accumulate and output
  dlm_mac u_mac (
    .clk            (clk),
    .rst_n          (rst_n),
    .s1_vld         (s1_vld),
    .s1_ctl         (s1_ctl),
    .s1_value       (s1_value),
    .s1_bias        (s1_bias),
    .act_rd         ($signed(ram_rdata)),
    .out_stall      (out_stall),
    .adv            (adv),
    .out_valid      (out_valid),
    .out_neuron     (out_neuron),
    .out_activation (out_activation),
    .out_clipped    (out_clipped),
    .out_final_res  (out_final_res)
  );

endmodule
